// ===== hdl/escape_sequence_decoder_macros.svh =====
// Assertion macros for the escape sequence decoder.
// Used by the top level only; needs nothing else.
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esd check failed");

// Next-cycle implication, checked outside reset.
`define ESD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esd check failed");

`endif

// ===== hdl/esd_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
// No dependencies.
`default_nettype none

package esd_pkg;

  localparam int MaxLen      = 4096;
  localparam int PosW        = 12;
  localparam int PosLimitInt = ((MaxLen - 1) < 4095) ? (MaxLen - 1) : 4095;
  localparam logic [PosW-1:0] PosLimit = PosW'(PosLimitInt);

  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [1:0]      status;
    logic [7:0]      data;
    logic [PosW-1:0] pos;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/esd_in_reg.sv =====
// Input register stage: holds one character until the decoder takes it.
// Depends on nothing but its ports.
`default_nettype none

module esd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       take,
  output logic       v,
  output logic [7:0] ch
);

  logic       v_r;
  logic [7:0] ch_r;

  assign in_ready = !v_r || take;
  assign v        = v_r;
  assign ch       = ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= in_ch;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/esd_decode.sv =====
// Decode state machine: escape mode, pending high nibble and char position.
// Uses esd_pkg for status codes, position limit and the result struct.
`default_nettype none

module esd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    ch,
  output esd_pkg::res_t res
);
  import esd_pkg::*;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_HEX_HI  = 3'd2,
    MODE_HEX_LO  = 3'd3,
    MODE_DISCARD = 3'd4
  } mode_t;

  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChBsl  = 8'h5C;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpF  = 8'h46;
  localparam logic [7:0] ChN    = 8'h6E;
  localparam logic [7:0] ChX    = 8'h78;
  localparam logic [7:0] ChLf   = 8'h0A;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    begin
      hex_val = 5'h10;
      if (c >= ChZero && c <= ChNine) begin
        t = c - ChZero;
        hex_val = {1'b0, t[3:0]};
      end else if (c >= ChLowA && c <= ChLowF) begin
        t = c - ChLowA + 8'd10;
        hex_val = {1'b0, t[3:0]};
      end else if (c >= ChUpA && c <= ChUpF) begin
        t = c - ChUpA + 8'd10;
        hex_val = {1'b0, t[3:0]};
      end
    end
  endfunction

  mode_t           mode_r, mode_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [4:0]      hv;

  assign hv = hex_val(ch);

  always_comb begin
    res      = '0;
    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    pos_nxt  = (pos_r < PosLimit) ? pos_r + 1'b1 : pos_r;
    if (ch == ChNul) begin
      if (mode_r != MODE_DISCARD) begin
        res.valid  = 1'b1;
        res.status = ST_DONE;
      end
      mode_nxt = MODE_NORMAL;
      nib_nxt  = '0;
      pos_nxt  = '0;
    end else begin
      case (mode_r)
        MODE_ESCAPE: begin
          if (ch == ChBsl || ch == ChZero || ch == ChN) begin
            res.valid  = 1'b1;
            res.status = ST_DATA;
            res.data   = (ch == ChBsl) ? ChBsl : (ch == ChN) ? ChLf : ChNul;
            mode_nxt   = MODE_NORMAL;
          end else if (ch == ChX) begin
            mode_nxt = MODE_HEX_HI;
          end else begin
            res.valid  = 1'b1;
            res.status = ST_ERROR;
            res.pos    = pos_r;
            mode_nxt   = MODE_DISCARD;
          end
        end
        MODE_HEX_HI: begin
          if (hv[4]) begin
            res.valid  = 1'b1;
            res.status = ST_ERROR;
            res.pos    = pos_r;
            mode_nxt   = MODE_DISCARD;
          end else begin
            nib_nxt  = hv[3:0];
            mode_nxt = MODE_HEX_LO;
          end
        end
        MODE_HEX_LO: begin
          res.valid = 1'b1;
          if (hv[4]) begin
            res.status = ST_ERROR;
            res.pos    = pos_r;
            mode_nxt   = MODE_DISCARD;
          end else begin
            res.status = ST_DATA;
            res.data   = {nib_r, hv[3:0]};
            mode_nxt   = MODE_NORMAL;
          end
        end
        MODE_DISCARD: begin
        end
        default: begin
          if (ch == ChBsl) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            res.valid  = 1'b1;
            res.status = ST_DATA;
            res.data   = ch;
            mode_nxt   = MODE_NORMAL;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      nib_r  <= '0;
      pos_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/esd_out_reg.sv =====
// Result register: holds one result until the sink takes it.
// Uses esd_pkg for the result struct.
`default_nettype none

module esd_out_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  esd_pkg::res_t             d,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [7:0]                out_byte,
  output logic [esd_pkg::PosW-1:0]  out_error_pos
);
  import esd_pkg::*;

  logic            v_r;
  logic [1:0]      status_r;
  logic [7:0]      byte_r;
  logic [PosW-1:0] pos_r;

  // slot frees up in the same cycle the held transaction drains
  assign free          = !v_r || out_ready;
  assign out_valid     = v_r;
  assign out_status    = status_r;
  assign out_byte      = byte_r;
  assign out_error_pos = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (free) begin
      v_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      status_r <= d.status;
      byte_r   <= d.data;
      pos_r    <= d.pos;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/escape_sequence_decoder.sv =====
// Top level of the backslash escape sequence decoder.
// Uses esd_pkg, esd_in_reg, esd_decode, esd_out_reg and the assertion macros.
//
//   channel  | ports                                         | role
//   ---------+-----------------------------------------------+-------------------
//   input    | in_valid, in_ready, in_ch                     | one char per transaction
//   result   | out_valid, out_ready, out_status, out_byte,   | 0 or 1 result
//            | out_error_pos                                 | per char
//
// One character per cycle sustained while the result side keeps up; a result
// passes through the input register, then the result register, to out_valid.
// Decoding state advances when the staged char moves on; a char that yields
// no result moves on even while the result register is stalled.
// rst_n is synchronous, active low; there is no clearing pass.
`default_nettype none
`include "escape_sequence_decoder_macros.svh"

module escape_sequence_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_ch,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [7:0]               out_byte,
  output logic [esd_pkg::PosW-1:0] out_error_pos
);
  import esd_pkg::*;

  logic       stg_v;
  logic [7:0] stg_ch;
  logic       step;
  logic       out_free;
  res_t       res;

  assign step = stg_v && (!res.valid || out_free);

  esd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .take     (step),
    .v        (stg_v),
    .ch       (stg_ch)
  );

  esd_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (stg_ch),
    .res   (res)
  );

  esd_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (step && res.valid),
    .d             (res),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_byte      (out_byte),
    .out_error_pos (out_error_pos)
  );

  `ESD_ASSERT_NOW(a_status_legal, clk, rst_n, out_valid, out_status != 2'd3)
  `ESD_ASSERT_NOW(a_byte_zero, clk, rst_n, out_valid && out_status != ST_DATA, out_byte == 8'd0)
  `ESD_ASSERT_NOW(a_pos_zero, clk, rst_n, out_valid && out_status != ST_ERROR, out_error_pos == '0)
  `ESD_ASSERT_NEXT(a_result_lands, clk, rst_n, step && res.valid, out_valid)

endmodule

`default_nettype wire

// ===== dv/escape_sequence_decoder_tb.sv =====
`timescale 1ns / 1ps
// Testbench for escape_sequence_decoder: streams strings of escapes into the
// block and scores every result against a cycle-free decoder prediction.
// Depends on esd_pkg and the escape_sequence_decoder RTL.

typedef logic [7:0] char_q_t[$];

typedef enum logic [2:0] {
  DM_NORMAL,
  DM_ESCAPE,
  DM_HEX_HI,
  DM_HEX_LO,
  DM_DISCARD
} decode_mode_t;

typedef struct packed {
  logic [1:0]               status;
  logic [7:0]               data;
  logic [esd_pkg::PosW-1:0] pos;
} decoded_t;

localparam logic [7:0] CH_NUL    = 8'h00;
localparam logic [7:0] CH_BSLASH = 8'h5C;
localparam logic [7:0] CH_ZERO   = "0";
localparam logic [7:0] CH_N      = "n";
localparam logic [7:0] CH_X      = "x";
localparam logic [7:0] CH_BAD    = "z";
localparam logic [7:0] CH_LF     = 8'h0A;
localparam logic [4:0] HEX_NONE  = 5'd16;

// Value of a hex digit, or HEX_NONE when the char is not one.
function automatic logic [4:0] hex_nibble(logic [7:0] c);
  if (c >= "0" && c <= "9") return 5'(c - "0");
  if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
  if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
  return HEX_NONE;
endfunction

class decoded_result_board;
  decode_mode_t             mode     = DM_NORMAL;
  logic [3:0]               nibble   = '0;
  logic [esd_pkg::PosW-1:0] position = '0;
  decoded_t                 pending_decodes[$];
  int errors    = 0;
  int n_chars   = 0;
  int n_data    = 0;
  int n_done    = 0;
  int n_perr    = 0;
  int max_epos  = 0;

  function int pending();
    return pending_decodes.size();
  endfunction

  function void expect_result(logic [1:0] st, logic [7:0] b, logic [esd_pkg::PosW-1:0] p);
    decoded_t e;
    e.status = st;
    e.data   = b;
    e.pos    = p;
    pending_decodes = {pending_decodes, e};
  endfunction

  // Advance the decoder by one accepted input transaction.
  function void note_char(logic [7:0] c);
    logic [4:0] v;
    v = hex_nibble(c);
    n_chars++;
    if (c == CH_NUL) begin
      if (mode != DM_DISCARD) expect_result(esd_pkg::ST_DONE, 8'h00, '0);
      mode     = DM_NORMAL;
      nibble   = '0;
      position = '0;
      return;
    end
    case (mode)
      DM_ESCAPE: begin
        if (c == CH_BSLASH) begin
          expect_result(esd_pkg::ST_DATA, CH_BSLASH, '0);
          mode = DM_NORMAL;
        end else if (c == CH_ZERO) begin
          expect_result(esd_pkg::ST_DATA, 8'h00, '0);
          mode = DM_NORMAL;
        end else if (c == CH_N) begin
          expect_result(esd_pkg::ST_DATA, CH_LF, '0);
          mode = DM_NORMAL;
        end else if (c == CH_X) begin
          mode = DM_HEX_HI;
        end else begin
          expect_result(esd_pkg::ST_ERROR, 8'h00, position);
          mode = DM_DISCARD;
        end
      end
      DM_HEX_HI: begin
        if (v == HEX_NONE) begin
          expect_result(esd_pkg::ST_ERROR, 8'h00, position);
          mode = DM_DISCARD;
        end else begin
          nibble = v[3:0];
          mode   = DM_HEX_LO;
        end
      end
      DM_HEX_LO: begin
        if (v == HEX_NONE) begin
          expect_result(esd_pkg::ST_ERROR, 8'h00, position);
          mode = DM_DISCARD;
        end else begin
          expect_result(esd_pkg::ST_DATA, {nibble, v[3:0]}, '0);
          mode = DM_NORMAL;
        end
      end
      DM_DISCARD: ;
      default: begin
        if (c == CH_BSLASH) begin
          mode = DM_ESCAPE;
        end else begin
          expect_result(esd_pkg::ST_DATA, c, '0);
          mode = DM_NORMAL;
        end
      end
    endcase
    if (position < esd_pkg::PosLimit) position++;
  endfunction

  function void check_result(logic [1:0] st, logic [7:0] b, logic [esd_pkg::PosW-1:0] p);
    decoded_t e;
    if (pending_decodes.size() == 0) begin
      $error("unexpected result: status %0d byte 0x%02h pos %0d", st, b, p);
      errors++;
      return;
    end
    e = pending_decodes.pop_front();
    if (st !== e.status) begin
      $error("out_status mismatch: expected %0d, actual %0d", e.status, st);
      errors++;
    end
    if (b !== e.data) begin
      $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", e.data, b);
      errors++;
    end
    if (p !== e.pos) begin
      $error("out_error_pos mismatch: expected %0d, actual %0d", e.pos, p);
      errors++;
    end
    case (e.status)
      esd_pkg::ST_DATA: n_data++;
      esd_pkg::ST_DONE: n_done++;
      default: begin
        n_perr++;
        if (int'(e.pos) > max_epos) max_epos = int'(e.pos);
      end
    endcase
  endfunction
endclass

module escape_sequence_decoder_tb;
  localparam int WatchdogLimit = 4000;
  localparam int LongHold      = 300;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               in_ch;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_status;
  logic [7:0]               out_byte;
  logic [esd_pkg::PosW-1:0] out_error_pos;

  decoded_result_board sb = new;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int n_sent   = 0;
  int idle_cycles = 0;

  escape_sequence_decoder DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_byte     (out_byte),
    .out_error_pos(out_error_pos)
  );

  always #5 clk = ~clk;

  // Both channels are scored from edge-sampled values; also the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_ch);
      if (out_valid && out_ready) sb.check_result(out_status, out_byte, out_error_pos);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no transaction for %0d cycles", WatchdogLimit);
        $display("FAIL escape_sequence_decoder");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [7:0] hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_BSLASH);
    return c;
  endfunction

  // Mostly well-formed strings; a few broken escapes and some raw noise.
  function automatic char_q_t make_string();
    char_q_t    s;
    int         n_tok;
    int         kind;
    logic [7:0] c;
    n_tok = $urandom_range(0, 12);
    if ($urandom_range(0, 6) == 0) begin
      repeat (n_tok + 1) s = {s, 8'($urandom_range(1, 255))};
    end else begin
      repeat (n_tok) begin
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
          s = {s, plain_char()};
        end else if (kind < 68) begin
          s = {s, CH_BSLASH};
          case ($urandom_range(0, 2))
            0:       s = {s, CH_BSLASH};
            1:       s = {s, CH_ZERO};
            default: s = {s, CH_N};
          endcase
        end else if (kind < 92) begin
          s = {s, CH_BSLASH, CH_X};
          s = {s, hex_digit()};
          s = {s, hex_digit()};
        end else if (kind < 96) begin
          do c = 8'($urandom_range(1, 255));
          while (c == CH_BSLASH || c == CH_ZERO || c == CH_N || c == CH_X);
          s = {s, CH_BSLASH, c};
        end else begin
          s = {s, CH_BSLASH, CH_X};
          if ($urandom_range(0, 1)) s = {s, hex_digit()};
          do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) != HEX_NONE);
          s = {s, c};
        end
      end
      // occasionally leave an escape unfinished at the terminator
      case ($urandom_range(0, 9))
        0: s = {s, CH_BSLASH};
        1: begin
          s = {s, CH_BSLASH, CH_X};
        end
        2: begin
          s = {s, CH_BSLASH, CH_X};
          s = {s, hex_digit()};
        end
        default: ;
      endcase
    end
    s = {s, CH_NUL};
    return s;
  endfunction

  // Plain run, then a bad escape; puts the error deep in the string.
  function automatic char_q_t make_long(int n_plain);
    char_q_t s;
    repeat (n_plain) s = {s, plain_char()};
    s = {s, CH_BSLASH, CH_BAD};
    repeat (3) s = {s, plain_char()};
    s = {s, CH_NUL};
    return s;
  endfunction

  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_seq(input char_q_t s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_random(input int target);
    while (n_sent < target) send_seq(make_string());
  endtask

  // Sender pause until the scoreboard has nothing outstanding.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_ch    = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // char extremes, every escape kind, an unfinished escape, both error kinds
    send_seq('{8'h01, 8'hFF, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_ZERO,
               CH_BSLASH, CH_N, CH_BSLASH, CH_X, "a", "F", CH_NUL,
               CH_BSLASH, CH_X, "9", CH_NUL,
               CH_BSLASH, "q", "A", CH_NUL,
               CH_BSLASH, CH_X, "0", "G", CH_NUL});

    send_random(n_sent + 150);
    hold_req = 1'b1;
    send_random(n_sent + 60);
    wait_for_results();
    send_random(n_sent + 140);
    send_seq(make_long($urandom_range(20, 60)));
    quiet = 1'b1;
    send_random(n_sent + 120);
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d chars; checked %0d data bytes, %0d done, %0d parse errors",
             sb.n_chars, sb.n_data, sb.n_done, sb.n_perr);
    $display("Highest error position seen: %0d (position limit %0d)",
             sb.max_epos, esd_pkg::PosLimit);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS escape_sequence_decoder");
    end else begin
      $display("FAIL escape_sequence_decoder");
    end
    $finish;
  end
endmodule
